### hdl/i2cmrt_pkg.sv
// Shared types and constants for the I2C register transfer engine.
// No dependencies.
package i2cmrt_pkg;

    localparam int BufDepthDefault = 16;
    localparam logic [15:0] UnitTicksReset = 16'd72;
    localparam logic [7:0]  AckTimeoutReset = 8'd250;
    localparam logic [15:0] BusFreeReset = 16'd2000;
    localparam logic [7:0]  MsbMask = 8'h80;
    localparam logic [15:0] EdgeUnits = 16'd4;
    localparam logic [15:0] HalfUnits = 16'd2;
    localparam logic [15:0] AckHalfUnits = 16'd1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_UNIT_TICKS = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1,
        CFG_BUS_FREE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_TIMEOUT = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    // One request as it travels from the front part to the engine.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] data_byte;
        logic [7:0] read_length;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_enable;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic [1:0] error_code;
        logic       busy_res;
    } res_t;

endpackage

### hdl/i2c_master_register_transfer.sv
// Top level of the I2C register transfer engine.
// Depends on i2cmrt_pkg, i2cmrt_fifo and i2cmrt_engine.
//
// Usage: every request (tick, load, begin write, begin read) enters through
// push/full and yields exactly one result, read through empty/pop in order.
// Ticks move the bus timing; unit_ticks ticks make one microsecond unit.
// The front part registers each request into a two-entry queue; the engine
// takes one request per cycle from it, while its output register is free,
// and writes the result into that output register. A request is registered
// in the queue and then in the output register before empty goes low.
// When pop stays low the output register holds, the engine stops taking
// requests, the queue fills and full rises; nothing is lost.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 unit_ticks,
// 1 ack_timeout, 2 bus_free_units; cfg_ready is always high. Write only
// while idle. Reset (rst_n low, asynchronous) empties both queues, returns
// the sequencer to idle, empties the write buffer and loads register
// defaults. Buffer contents are undefined until loaded and never read unloaded.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
#(
    parameter int BUF_DEPTH = BufDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  dev_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  read_length,
    input  logic        sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        scl,
    output logic        sda_out,
    output logic        sda_enable,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        read_last,
    output logic        done_res,
    output logic [1:0]  error_code,
    output logic        busy_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int ReqW = $bits(req_t);

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;
    logic [15:0] bus_free_reg;
    req_t        push_req, q_req;
    logic [ReqW-1:0] q_bits;
    logic        q_empty, eng_ready, res_valid;
    res_t        res;

    assign cfg_ready = 1'b1;

    // Hold configuration; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UnitTicksReset;
            ack_timeout_reg <= AckTimeoutReset;
            bus_free_reg <= BusFreeReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_UNIT_TICKS: unit_ticks_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                CFG_BUS_FREE: bus_free_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign push_req = '{command: command, dev_addr: dev_addr, reg_addr: reg_addr,
                        data_byte: data_byte, read_length: read_length, sda_in: sda_in};

    // Front queue: decouple request intake from the sequencer.
    i2cmrt_fifo #(.WIDTH(ReqW), .DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(push_req), .full(full),
        .rd_en(eng_ready), .rd_data(q_bits), .empty(q_empty)
    );
    assign q_req = req_t'(q_bits);

    i2cmrt_engine #(.BUF_DEPTH(BUF_DEPTH)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(!q_empty), .req(q_req), .req_ready(eng_ready),
        .res_valid(res_valid), .res(res), .res_ready(pop),
        .unit_ticks(unit_ticks_reg), .ack_timeout(ack_timeout_reg),
        .bus_free_units(bus_free_reg)
    );

    assign empty = !res_valid;
    assign scl = res.scl;
    assign sda_out = res.sda_out;
    assign sda_enable = res.sda_enable;
    assign read_valid = res.read_valid;
    assign read_data = res.read_data;
    assign read_last = res.read_last;
    assign done_res = res.done_res;
    assign error_code = res.error_code;
    assign busy_res = res.busy_res;

    assert property (@(posedge clk) disable iff (!rst_n)
        (!sda_enable && !empty) |-> sda_out)
        else $error("sda_out low while released");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !read_valid) |-> (read_data == 8'h00 && !read_last))
        else $error("read data without read_valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done while still busy");
endmodule

### hdl/i2cmrt_fifo.sv
// Small synchronous FIFO used between the front part and the engine.
// Depends on nothing but its parameters.
module i2cmrt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) return '0;
        return p + AW'(1);
    endfunction

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= inc(wp_reg);
            end
            if (rd_en && !empty)
            begin
                rp_reg <= inc(rp_reg);
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("fifo full and empty at once");
    assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(wr_en && !full)) |=> empty)
        else $error("fifo became non-empty without a write");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !(rd_en && !empty)) |=> full)
        else $error("fifo left full without a read");
endmodule

### hdl/i2cmrt_engine.sv
// Back part: bus sequencer, write buffer and timing counters, one request per cycle
// while the result register is free. Depends on i2cmrt_pkg.
module i2cmrt_engine
    import i2cmrt_pkg::*;
#(
    parameter int BUF_DEPTH = BufDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  req_t        req,
    output logic        req_ready,
    output logic        res_valid,
    output res_t        res,
    input  logic        res_ready,
    input  logic [15:0] unit_ticks,
    input  logic [7:0]  ack_timeout,
    input  logic [15:0] bus_free_units
);
    localparam int BW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    // Bytes left must hold a full read length as well as a buffer count.
    localparam int LW = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_RD_LOW, PH_RD_HIGH,
        PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_FREE
    } phase_t;

    typedef enum logic [1:0] {
        ST_DEV, ST_REG, ST_DATA, ST_READ
    } stage_t;

    phase_t phase_reg, phase_next;
    stage_t stage_reg, stage_next;
    logic [15:0] unit_reg, unit_next, delay_reg, delay_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next, polls_reg, polls_next;
    logic [LW-1:0] left_reg, left_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  dev_reg, dev_next, regn_reg, regn_next;
    logic        read_reg, read_next, err_reg, err_next;
    logic        outv_reg;
    res_t        out_reg, out_next;

    logic [7:0]  buf_mem [BUF_DEPTH];
    logic        buf_we;
    logic [CW-1:0] rd_idx;
    logic [7:0]  buf_rd;
    logic        fire;

    // Output register frees when empty or being taken.
    assign req_ready = !outv_reg || res_ready;
    assign fire = req_valid && req_ready;
    assign res_valid = outv_reg;
    assign res = out_reg;

    // Index of the next byte to send, taken from the state before this request.
    assign rd_idx = count_reg - left_reg[CW-1:0];
    assign buf_rd = (rd_idx < CW'(BUF_DEPTH)) ? buf_mem[rd_idx[BW-1:0]] : 8'h00;

    always_ff @(posedge clk)
    begin
        if (buf_we && fire)
        begin
            buf_mem[count_reg[BW-1:0]] <= req.data_byte;
        end
    end

    always_comb
    begin
        logic [15:0] dur;
        logic [LW-1:0] lft;
        phase_next = phase_reg;
        stage_next = stage_reg;
        unit_next = unit_reg;
        delay_next = delay_reg;
        bit_next = bit_reg;
        shift_next = shift_reg;
        polls_next = polls_reg;
        left_next = left_reg;
        count_next = count_reg;
        dev_next = dev_reg;
        regn_next = regn_reg;
        read_next = read_reg;
        err_next = err_reg;
        buf_we = 1'b0;
        out_next = '0;
        lft = left_reg;

        case (phase_reg)
            PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: dur = EdgeUnits;
            PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL:         dur = AckHalfUnits;
            PH_FREE:                                      dur = bus_free_units;
            default:                                      dur = HalfUnits;
        endcase

        case (cmd_t'(req.command))
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    unit_next = unit_reg + 16'd1;
                    if (unit_next >= unit_ticks)
                    begin
                        unit_next = '0;
                        delay_next = delay_reg + 16'd1;
                        if (delay_next >= dur)
                        begin
                            delay_next = '0;
                            case (phase_reg)
                                PH_START_A: phase_next = PH_START_B;
                                PH_START_B:
                                begin
                                    shift_next = (stage_reg == ST_READ) ? (dev_reg | 8'h01)
                                                                        : (dev_reg & 8'hFE);
                                    bit_next = '0;
                                    phase_next = PH_BIT_LOW;
                                end
                                PH_BIT_LOW: phase_next = PH_BIT_HIGH;
                                PH_BIT_HIGH:
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    bit_next = bit_reg + 4'd1;
                                    if (bit_next >= 4'd8)
                                    begin
                                        polls_next = '0;
                                        phase_next = PH_ACK_LOW;
                                    end
                                    else
                                    begin
                                        phase_next = PH_BIT_LOW;
                                    end
                                end
                                PH_ACK_LOW: phase_next = PH_ACK_HIGH;
                                PH_ACK_HIGH: phase_next = PH_ACK_POLL;
                                PH_ACK_POLL:
                                begin
                                    if (!req.sda_in)
                                    begin
                                        case (stage_reg)
                                            ST_DEV:
                                            begin
                                                stage_next = ST_REG;
                                                shift_next = regn_reg;
                                                bit_next = '0;
                                                phase_next = PH_BIT_LOW;
                                            end
                                            ST_REG, ST_DATA:
                                            begin
                                                if (stage_reg == ST_REG && read_reg)
                                                begin
                                                    stage_next = ST_READ;
                                                    phase_next = PH_START_A;
                                                end
                                                else
                                                begin
                                                    if (stage_reg == ST_DATA && lft != '0)
                                                    begin
                                                        lft = lft - LW'(1);
                                                    end
                                                    left_next = lft;
                                                    if (lft == '0)
                                                    begin
                                                        phase_next = PH_STOP_A;
                                                    end
                                                    else
                                                    begin
                                                        stage_next = ST_DATA;
                                                        // One byte ahead: drop-by-one index.
                                                        shift_next = (stage_reg == ST_DATA)
                                                            ? buf_mem_next_byte() : buf_rd;
                                                        bit_next = '0;
                                                        phase_next = PH_BIT_LOW;
                                                    end
                                                end
                                            end
                                            default:
                                            begin
                                                if (left_reg != '0)
                                                begin
                                                    bit_next = '0;
                                                    shift_next = '0;
                                                    phase_next = PH_RD_LOW;
                                                end
                                                else
                                                begin
                                                    phase_next = PH_STOP_A;
                                                end
                                            end
                                        endcase
                                    end
                                    else if (polls_reg >= ack_timeout)
                                    begin
                                        err_next = 1'b1;
                                        phase_next = PH_STOP_A;
                                    end
                                    else
                                    begin
                                        polls_next = polls_reg + 8'd1;
                                    end
                                end
                                PH_RD_LOW: phase_next = PH_RD_HIGH;
                                PH_RD_HIGH:
                                begin
                                    shift_next = {shift_reg[6:0], req.sda_in};
                                    bit_next = bit_reg + 4'd1;
                                    if (bit_next >= 4'd8)
                                    begin
                                        out_next.read_valid = 1'b1;
                                        out_next.read_data = shift_next;
                                        out_next.read_last = (left_reg == LW'(1));
                                        phase_next = PH_MACK_LOW;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RD_LOW;
                                    end
                                end
                                PH_MACK_LOW: phase_next = PH_MACK_HIGH;
                                PH_MACK_HIGH:
                                begin
                                    if (lft != '0)
                                    begin
                                        lft = lft - LW'(1);
                                    end
                                    left_next = lft;
                                    if (lft == '0)
                                    begin
                                        phase_next = PH_STOP_A;
                                    end
                                    else
                                    begin
                                        bit_next = '0;
                                        shift_next = '0;
                                        phase_next = PH_RD_LOW;
                                    end
                                end
                                PH_STOP_A: phase_next = PH_STOP_B;
                                PH_STOP_B, PH_FREE:
                                begin
                                    if (phase_reg == PH_FREE || bus_free_units == '0)
                                    begin
                                        out_next.done_res = 1'b1;
                                        out_next.error_code = err_reg ? ERR_TIMEOUT : ERR_NONE;
                                        if (!read_reg)
                                        begin
                                            count_next = '0;
                                        end
                                        err_next = 1'b0;
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FREE;
                                    end
                                end
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                end
            end
            CMD_LOAD:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (count_reg < CW'(BUF_DEPTH))
                    begin
                        buf_we = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        out_next.error_code = ERR_OVERFLOW;
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    dev_next = req.dev_addr;
                    regn_next = req.reg_addr;
                    read_next = (cmd_t'(req.command) == CMD_READ);
                    left_next = read_next ? LW'(req.read_length) : LW'(count_reg);
                    stage_next = ST_DEV;
                    err_next = 1'b0;
                    polls_next = '0;
                    bit_next = '0;
                    shift_next = '0;
                    unit_next = '0;
                    delay_next = '0;
                    phase_next = PH_START_A;
                end
            end
        endcase

        out_next.scl = 1'b1;
        out_next.sda_out = 1'b1;
        out_next.sda_enable = 1'b1;
        case (phase_next)
            PH_START_B: out_next.sda_out = 1'b0;
            PH_BIT_LOW:
            begin
                out_next.scl = 1'b0;
                out_next.sda_out = |(shift_next & MsbMask);
            end
            PH_BIT_HIGH: out_next.sda_out = |(shift_next & MsbMask);
            PH_ACK_LOW, PH_RD_LOW:
            begin
                out_next.scl = 1'b0;
                out_next.sda_enable = 1'b0;
            end
            PH_ACK_HIGH, PH_ACK_POLL, PH_RD_HIGH: out_next.sda_enable = 1'b0;
            PH_MACK_LOW:
            begin
                out_next.scl = 1'b0;
                out_next.sda_out = (left_next == LW'(1));
            end
            PH_MACK_HIGH: out_next.sda_out = (left_next == LW'(1));
            PH_STOP_A:
            begin
                out_next.scl = 1'b0;
                out_next.sda_out = 1'b0;
            end
            default: ;
        endcase
        out_next.busy_res = (phase_next != PH_IDLE);
    end

    // Byte after the one just acknowledged: index grows by one as left drops.
    function automatic logic [7:0] buf_mem_next_byte();
        logic [CW-1:0] idx;
        idx = rd_idx + CW'(1);
        if (idx < CW'(BUF_DEPTH))
        begin
            return buf_mem[idx[BW-1:0]];
        end
        return 8'h00;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stage_reg <= ST_DEV;
            unit_reg <= '0;
            delay_reg <= '0;
            bit_reg <= '0;
            shift_reg <= '0;
            polls_reg <= '0;
            left_reg <= '0;
            count_reg <= '0;
            dev_reg <= '0;
            regn_reg <= '0;
            read_reg <= 1'b0;
            err_reg <= 1'b0;
            outv_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                stage_reg <= stage_next;
                unit_reg <= unit_next;
                delay_reg <= delay_next;
                bit_reg <= bit_next;
                shift_reg <= shift_next;
                polls_reg <= polls_next;
                left_reg <= left_next;
                count_reg <= count_next;
                dev_reg <= dev_next;
                regn_reg <= regn_next;
                read_reg <= read_next;
                err_reg <= err_next;
                out_reg <= out_next;
                outv_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                outv_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUF_DEPTH))
        else $error("write buffer count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_reg <= 4'd8))
        else $error("bit count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && !res_ready) |=> (outv_reg && $stable(out_reg)))
        else $error("result register changed while stalled");
endmodule
